// ===== rtl/core/gms_pkg.sv =====
package gms_pkg;

	localparam int CELL_W = 16;	// width of one grid cell value
	localparam int CFG_W = 7;	// width of a size register
	localparam int CFG_IDX_W = 8;	// width of the register index
	localparam int OUT_W = 22;	// width of the reported need

	// register indexes on the configuration channel
	localparam logic [CFG_IDX_W-1:0] REG_GRID_ROWS = 8'd0;
	localparam logic [CFG_IDX_W-1:0] REG_GRID_COLS = 8'd1;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SWEEP,
		ST_DRAIN
	} gms_state_t;

	// per-cell control of the row buffer chain
	typedef struct packed {
		logic shift;	// advance the chain this cycle
		logic load;	// this cell takes the fresh need instead of its neighbor's
	} gms_cell_ctl_t;

endpackage

// ===== rtl/core/gms_ram.sv =====
module gms_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 4096
) (
	input  logic                                  clk,
	input  logic                                  we,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                      wdata,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                      rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

// ===== rtl/core/gms_cell.sv =====
module gms_cell #(
	parameter int W = 22
) (
	input  logic                   clk,
	input  gms_pkg::gms_cell_ctl_t ctl,
	input  logic [W-1:0]           fresh,
	input  logic [W-1:0]           prev,
	output logic [W-1:0]           need
);
	import gms_pkg::*;

	logic [W-1:0] need_q;

	// take the new need at the entry cell, otherwise pass the neighbor's value on
	always_ff @(posedge clk) begin
		if (ctl.shift) begin
			need_q <= ctl.load ? fresh : prev;
		end
	end

	assign need = need_q;

endmodule

// ===== rtl/core/grid_min_start_health.sv =====
// Channel   Dir  Handshake                        Payload
// s_axis    in   s_axis_tvalid / s_axis_tready    cell_value [15:0], signed
// m_axis    out  m_axis_tvalid / m_axis_tready    min_health [21:0]
// cfg       in   cfg_valid / cfg_ready            cfg_index selects grid_rows or grid_cols
//
// Cells load at one per cycle into the cell store. The cell that completes the grid
// starts a backward sweep that reads the store once per cycle; the store's single read
// port sets this pace, and s_axis_tready stays low until the result registers.
// The row of need cells forms a shift chain whose length follows the column count.
// Reset clears the sizes to 1 and the load count to 0; the store and chain hold
// whatever they held. Loading runs on while m_axis stalls; only the cell that
// would start the next sweep waits until the pending result is taken.
module grid_min_start_health #(
	parameter int MAX_ROWS = 64,
	parameter int MAX_COLS = 64
) (
	input  logic                           clk,
	input  logic                           arst_n,
	// load channel
	input  logic                           s_axis_tvalid,
	output logic                           s_axis_tready,
	input  logic [15:0]                    s_axis_tdata,	// [15:0] cell_value
	// result channel
	output logic                           m_axis_tvalid,
	input  logic                           m_axis_tready,
	output logic [23:0]                    m_axis_tdata,	// [21:0] min_health, [23:22] zero
	// configuration channel
	input  logic                           cfg_valid,
	output logic                           cfg_ready,
	input  logic [gms_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [gms_pkg::CFG_W-1:0]      cfg_data
);
	import gms_pkg::*;

	localparam int DEPTH  = MAX_ROWS * MAX_COLS;
	localparam int AW     = DEPTH > 1 ? $clog2(DEPTH) : 1;
	localparam int TOT_W  = $clog2(DEPTH + 1);
	localparam int ROW_W  = $clog2(MAX_ROWS + 1);
	localparam int COL_W  = $clog2(MAX_COLS + 1);
	localparam int RI_W   = MAX_ROWS > 1 ? $clog2(MAX_ROWS) : 1;
	localparam int CI_W   = MAX_COLS > 1 ? $clog2(MAX_COLS) : 1;
	// largest need: one full path of the most negative cells, plus one
	localparam int NEED_W = $clog2((MAX_ROWS + MAX_COLS - 1) * 32768 + 2);
	localparam int DW     = NEED_W + 2;

	// clamp a size register into 1..maxv
	function automatic int clamp_size(input logic [CFG_W-1:0] v, input int maxv);
		int r;
		r = int'(v);
		if (r == 0) begin
			r = 1;
		end else if (r > maxv) begin
			r = maxv;
		end
		return r;
	endfunction

	// ---------------------------------------------------------------- config
	logic [CFG_W-1:0] grid_rows_q;
	logic [CFG_W-1:0] grid_cols_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			grid_rows_q <= CFG_W'(1);
			grid_cols_q <= CFG_W'(1);
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_GRID_ROWS: grid_rows_q <= cfg_data;
				REG_GRID_COLS: grid_cols_q <= cfg_data;
				default: ;	// drop writes beyond the register list
			endcase
		end
	end

	logic [ROW_W-1:0] rows;
	logic [COL_W-1:0] cols;
	logic [TOT_W-1:0] total;

	assign rows  = ROW_W'(clamp_size(grid_rows_q, MAX_ROWS));
	assign cols  = COL_W'(clamp_size(grid_cols_q, MAX_COLS));
	assign total = TOT_W'(rows * cols);

	// ---------------------------------------------------------------- control
	gms_state_t state_q, state_d;
	logic [AW-1:0]    load_count_q;
	logic [TOT_W-1:0] count_inc;
	logic             last_cell;
	logic             in_accept;
	logic             sweep_en;
	logic [AW-1:0]    addr_q;
	logic [RI_W-1:0]  r_q;
	logic [CI_W-1:0]  c_q;
	logic             valid_s1, below_s1, right_s1, last_s1;
	logic             m_valid_q;
	logic [NEED_W-1:0] need_out_q;

	assign count_inc = TOT_W'(load_count_q) + TOT_W'(1);
	assign last_cell = count_inc >= total;
	assign in_accept = s_axis_tvalid && s_axis_tready;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE:  if (in_accept && last_cell) state_d = ST_SWEEP;
			ST_SWEEP: if (addr_q == AW'(0)) state_d = ST_DRAIN;
			ST_DRAIN: state_d = ST_IDLE;
			default:  state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		s_axis_tready = 1'b0;
		sweep_en      = 1'b0;
		unique case (state_q)
			// hold the completing cell while a result still waits
			ST_IDLE:  s_axis_tready = !(last_cell && m_valid_q);
			ST_SWEEP: sweep_en = 1'b1;
			ST_DRAIN: ;
			default:  ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			load_count_q <= '0;
		end else begin
			state_q <= state_d;
			if (in_accept) begin
				load_count_q <= last_cell ? '0 : AW'(count_inc);
			end
		end
	end

	// sweep read address and grid position, walking from the bottom-right corner
	always_ff @(posedge clk) begin
		if (in_accept && last_cell) begin
			addr_q <= AW'(total - TOT_W'(1));
			r_q    <= RI_W'(rows - ROW_W'(1));
			c_q    <= CI_W'(cols - COL_W'(1));
		end else if (sweep_en) begin
			addr_q <= addr_q - AW'(1);
			if (c_q == CI_W'(0)) begin
				c_q <= CI_W'(cols - COL_W'(1));
				r_q <= r_q - RI_W'(1);
			end else begin
				c_q <= c_q - CI_W'(1);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= sweep_en;
		end
	end

	always_ff @(posedge clk) begin
		below_s1 <= r_q != RI_W'(rows - ROW_W'(1));
		right_s1 <= c_q != CI_W'(cols - COL_W'(1));
		last_s1  <= addr_q == AW'(0);
	end

	// ---------------------------------------------------------------- cell store
	logic [CELL_W-1:0] cell_rd;

	gms_ram #(
		.WIDTH(CELL_W),
		.DEPTH(DEPTH)
	) u_store (
		.clk  (clk),
		.we   (in_accept),
		.waddr(load_count_q),
		.wdata(s_axis_tdata),
		.raddr(addr_q),
		.rdata(cell_rd)
	);

	// ---------------------------------------------------------------- need update
	logic [NEED_W-1:0] need_chain [MAX_COLS];
	logic [NEED_W-1:0] below;
	logic [NEED_W-1:0] right_q;
	logic [NEED_W-1:0] best;
	logic signed [DW-1:0] diff;
	logic [NEED_W-1:0] need;

	// the need computed cols steps ago, for the cell just below, sits at the tail
	assign below = need_chain[MAX_COLS-1];

	always_comb begin
		if (below_s1 && right_s1) begin
			best = (below < right_q) ? below : right_q;
		end else if (right_s1) begin
			best = right_q;
		end else if (below_s1) begin
			best = below;
		end else begin
			best = NEED_W'(1);
		end
		diff = signed'(DW'(best)) - DW'(signed'(cell_rd));
		need = (diff < signed'(DW'(1))) ? NEED_W'(1) : NEED_W'(diff);
	end

	always_ff @(posedge clk) begin
		if (valid_s1) begin
			right_q <= need;
		end
	end

	// ---------------------------------------------------------------- row buffer chain
	logic [CI_W-1:0] entry_idx;

	// shorten the chain to cols cells by entering at MAX_COLS - cols
	assign entry_idx = CI_W'(MAX_COLS) - CI_W'(cols);

	for (genvar i = 0; i < MAX_COLS; i++) begin : g_cell
		gms_cell_ctl_t ctl;
		logic [NEED_W-1:0] prev;

		assign ctl.shift = valid_s1;
		assign ctl.load  = entry_idx == CI_W'(i);
		if (i == 0) begin : g_head
			assign prev = need;
		end else begin : g_body
			assign prev = need_chain[i-1];
		end

		gms_cell #(
			.W(NEED_W)
		) u_cell (
			.clk  (clk),
			.ctl  (ctl),
			.fresh(need),
			.prev (prev),
			.need (need_chain[i])
		);
	end

	// ---------------------------------------------------------------- result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (valid_s1 && last_s1) begin
			m_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			m_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (valid_s1 && last_s1) begin
			need_out_q <= need;
		end
	end

	logic [NEED_W+OUT_W-1:0] need_wide;

	assign need_wide     = (NEED_W + OUT_W)'(need_out_q);
	assign m_axis_tvalid = m_valid_q;
	assign m_axis_tdata  = {2'b00, need_wide[OUT_W-1:0]};

endmodule
